/* sv/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PBSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbsp assertion failed");
`define PBSP_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pbsp forbidden condition");
`else
`define PBSP_ASSERT(label, clk, rst, prop)
`define PBSP_NEVER(label, clk, rst, expr)
`endif

`endif

/* sv/pbsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pbsp_pkg;

   localparam int CELL_COUNT = 4096;
   localparam int CELL_AW    = 12;

   typedef enum logic [1:0] {
      OP_WRITE_CELL = 2'd0,
      OP_READ_CELL  = 2'd1,
      OP_READ_WORD  = 2'd2,
      OP_READ_PAL   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT,
      ST_CELL_RD,
      ST_PAL_LOOKUP,
      ST_PAL_RD,
      ST_PACK_INIT,
      ST_PACK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic srch;
      logic commit;
      logic cell_rd;
      logic pal_lookup;
      logic pal_item;
      logic pack_init;
      logic pack_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic srch_done;
      logic pack_done;
      logic out_busy;
   } status_type;

   // index width from palette count: 1..6 kept, 7..8 -> 8, above -> 16
   function automatic logic [4:0] bpc_for_count(input logic [31:0] count);
      logic [31:0] n;
      logic [4:0]  b;
      n = (count < 32'd2) ? 32'd2 : count;
      b = 5'd0;
      for (int j = 0; j < 17; j++) begin
         if ((32'd1 << j) < n) b = 5'(j + 1);
      end
      if (b > 5'd8) b = 5'd16;
      else if (b > 5'd6) b = 5'd8;
      return b;
   endfunction

   function automatic logic [5:0] per_word_for(input logic [4:0] bpc);
      logic [5:0] r;
      case (bpc)
         5'd1:    r = 6'd32;
         5'd2:    r = 6'd16;
         5'd3:    r = 6'd10;
         5'd4:    r = 6'd8;
         5'd5:    r = 6'd6;
         5'd6:    r = 6'd5;
         5'd8:    r = 6'd4;
         default: r = 6'd2;
      endcase
      return r;
   endfunction

   function automatic logic [11:0] words_for(input logic [4:0] bpc);
      logic [11:0] r;
      case (bpc)
         5'd1:    r = 12'd128;
         5'd2:    r = 12'd256;
         5'd3:    r = 12'd410;
         5'd4:    r = 12'd512;
         5'd5:    r = 12'd683;
         5'd6:    r = 12'd820;
         5'd8:    r = 12'd1024;
         default: r = 12'd2048;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/pbsp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbsp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic [1:0]          req_op,
   output logic                     req_tready,
   input  wire pbsp_pkg::status_type status,
   output pbsp_pkg::cmd_type        cmd
);
   import pbsp_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (status.clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (op_type'(req_op))
                  OP_WRITE_CELL: state_in = ST_SEARCH;
                  OP_READ_CELL:  state_in = ST_CELL_RD;
                  OP_READ_WORD:  state_in = ST_PACK_INIT;
                  OP_READ_PAL:   state_in = ST_PAL_RD;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH:     if (status.srch_done) state_in = ST_COMMIT;
         ST_COMMIT:     state_in = ST_DONE;
         ST_CELL_RD:    state_in = ST_PAL_LOOKUP;
         ST_PAL_LOOKUP: state_in = ST_DONE;
         ST_PAL_RD:     state_in = ST_DONE;
         ST_PACK_INIT:  state_in = ST_PACK;
         ST_PACK:       if (status.pack_done) state_in = ST_DONE;
         ST_DONE:       if (!status.out_busy) state_in = ST_IDLE;
         default:       state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:      cmd.clear = 1'b1;
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_SEARCH:     cmd.srch = 1'b1;
         ST_COMMIT:     cmd.commit = 1'b1;
         ST_CELL_RD:    cmd.cell_rd = 1'b1;
         ST_PAL_LOOKUP: cmd.pal_lookup = 1'b1;
         ST_PAL_RD:     cmd.pal_item = 1'b1;
         ST_PACK_INIT:  cmd.pack_init = 1'b1;
         ST_PACK:       cmd.pack_step = 1'b1;
         ST_DONE:       cmd.load_out = !status.out_busy;
         default:       cmd = '0;
      endcase
   end

   `PBSP_ASSERT(a_search_to_commit, clock, reset,
      (state_ff == ST_SEARCH && status.srch_done) |=> cmd.commit)
   `PBSP_ASSERT(a_commit_then_done, clock, reset, cmd.commit |=> state_ff == ST_DONE)
   `PBSP_ASSERT(a_result_frees_ctrl, clock, reset, cmd.load_out |=> req_tready)
   `PBSP_NEVER(n_load_while_busy, clock, reset, cmd.load_out && status.out_busy)

endmodule
`default_nettype wire

/* sv/pbsp_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbsp_dpath #(
   parameter int PALETTE_DEPTH = 4096,
   parameter int PA_W          = $clog2(PALETTE_DEPTH),
   parameter int CNT_W         = $clog2(PALETTE_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pbsp_pkg::cmd_type    cmd,
   output pbsp_pkg::status_type      status,
   input  wire logic [1:0]           req_op,
   input  wire logic [3:0]           req_pos_x,
   input  wire logic [3:0]           req_pos_y,
   input  wire logic [3:0]           req_pos_z,
   input  wire logic [31:0]          req_new_state,
   input  wire logic [11:0]          req_item_index,
   input  wire logic                 rsp_tready,
   output logic                      rsp_valid,
   output logic [31:0]               rsp_cell_state,
   output logic [31:0]               rsp_packed_word,
   output logic [31:0]               rsp_palette_zigzag,
   output logic [4:0]                rsp_bits_per_cell,
   output logic [7:0]                rsp_header_byte,
   output logic [11:0]               rsp_word_count,
   output logic [CNT_W-1:0]          rsp_palette_count,
   output logic                      rsp_store_empty,
   output logic                      rsp_palette_full,
   output logic                      rsp_index_ok
);
   import pbsp_pkg::*;

   logic [31:0]      pal_mem  [PALETTE_DEPTH];
   logic [PA_W-1:0]  cell_mem [CELL_COUNT];

   // captured request
   logic [1:0]         op_ff;
   logic [CELL_AW-1:0] addr_ff;
   logic [31:0]        st_ff;
   logic [11:0]        item_ff;

   logic [CNT_W-1:0]   used_ff;
   logic [CELL_AW:0]   clr_cnt_ff;
   logic               full_ff;

   // memory read ports
   logic [31:0]        pal_rd_ff;
   logic [PA_W-1:0]    cell_rd_ff;
   logic               pal_re, cell_re;
   logic [PA_W-1:0]    pal_raddr;
   logic [CELL_AW-1:0] cell_raddr;

   // palette search
   logic [CNT_W-1:0]   srch_cnt_ff;
   logic               cmp_vld_ff;
   logic [PA_W-1:0]    cmp_idx_ff;
   logic               srch_done_ff, srch_hit_ff;
   logic [PA_W-1:0]    hit_idx_ff;
   logic               srch_issue, cmp_match, cmp_last;

   // packing
   logic [17:0]        base_ff;
   logic               wok_ff;
   logic [5:0]         iss_k_ff, lag_k_ff;
   logic               lag_vld_ff;
   logic [31:0]        acc_ff;
   logic [17:0]        pack_c;
   logic               pack_issue;
   logic [10:0]        shamt;

   logic [4:0]         bpc;
   logic [5:0]         per_word;
   logic [11:0]        words;
   logic               pal_ok;
   logic [31:0]        item_ext;
   logic [CELL_AW-1:0] req_addr;
   logic               used_room;

   assign bpc       = bpc_for_count(32'(used_ff));
   assign per_word  = per_word_for(bpc);
   assign words     = words_for(bpc);
   assign item_ext  = {20'd0, item_ff};
   assign pal_ok    = item_ext < 32'(used_ff);
   assign req_addr  = {req_pos_x, req_pos_z, req_pos_y};
   assign used_room = used_ff < CNT_W'(PALETTE_DEPTH);

   assign srch_issue = cmd.srch && !srch_done_ff && (srch_cnt_ff < used_ff);
   assign cmp_match  = cmp_vld_ff &&
                       ((cmp_idx_ff == '0) ? (st_ff == 32'd0) : (pal_rd_ff == st_ff));
   assign cmp_last   = CNT_W'(cmp_idx_ff) == (used_ff - CNT_W'(1));

   assign pack_c     = base_ff + 18'(iss_k_ff);
   assign pack_issue = cmd.pack_step && wok_ff && (iss_k_ff < per_word) &&
                       (pack_c < 18'(CELL_COUNT));
   assign shamt      = lag_k_ff * bpc;

   always_comb begin
      pal_re    = srch_issue || cmd.pal_lookup || cmd.pal_item;
      pal_raddr = srch_cnt_ff[PA_W-1:0];
      if (cmd.pal_lookup)    pal_raddr = cell_rd_ff;
      else if (cmd.pal_item) pal_raddr = item_ext[PA_W-1:0];
      cell_re    = cmd.cell_rd || pack_issue;
      cell_raddr = pack_issue ? pack_c[CELL_AW-1:0] : addr_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (pal_re) pal_rd_ff <= pal_mem[pal_raddr];
      if (cmd.commit && !srch_hit_ff && used_room)
         pal_mem[used_ff[PA_W-1:0]] <= st_ff;
   end

   always_ff @(posedge clock) begin
      if (cell_re) cell_rd_ff <= cell_mem[cell_raddr];
      if (cmd.clear)
         cell_mem[clr_cnt_ff[CELL_AW-1:0]] <= '0;
      else if (cmd.commit && srch_hit_ff)
         cell_mem[addr_ff] <= hit_idx_ff;
      else if (cmd.commit && used_room)
         cell_mem[addr_ff] <= used_ff[PA_W-1:0];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         addr_ff <= req_addr;
         st_ff   <= req_new_state;
         item_ff <= req_item_index;
      end
      if (cmd.srch) begin
         cmp_idx_ff <= srch_cnt_ff[PA_W-1:0];
         if (cmp_match && !srch_done_ff) hit_idx_ff <= cmp_idx_ff;
      end
      if (cmd.pack_init) begin
         base_ff <= 18'(item_ff * per_word);
         acc_ff  <= '0;
      end else if (cmd.pack_step && lag_vld_ff) begin
         acc_ff <= acc_ff | (32'(cell_rd_ff) << shamt[4:0]);
      end
      if (cmd.pack_step) lag_k_ff <= iss_k_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= CNT_W'(1);
         clr_cnt_ff   <= '0;
         full_ff      <= 1'b0;
         srch_cnt_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         srch_done_ff <= 1'b0;
         srch_hit_ff  <= 1'b0;
         wok_ff       <= 1'b0;
         iss_k_ff     <= '0;
         lag_vld_ff   <= 1'b0;
      end else begin
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.load_req) begin
            full_ff      <= 1'b0;
            srch_cnt_ff  <= '0;
            cmp_vld_ff   <= 1'b0;
            srch_done_ff <= 1'b0;
            srch_hit_ff  <= 1'b0;
         end
         if (cmd.srch && !srch_done_ff) begin
            cmp_vld_ff <= srch_issue;
            if (srch_issue) srch_cnt_ff <= srch_cnt_ff + 1'b1;
            if (cmp_match) begin
               srch_done_ff <= 1'b1;
               srch_hit_ff  <= 1'b1;
            end else if (cmp_vld_ff && cmp_last) begin
               srch_done_ff <= 1'b1;
            end
         end
         if (cmd.commit && !srch_hit_ff) begin
            if (used_room) used_ff <= used_ff + 1'b1;
            else           full_ff <= 1'b1;
         end
         if (cmd.pack_init) begin
            wok_ff     <= item_ff < words;
            iss_k_ff   <= '0;
            lag_vld_ff <= 1'b0;
         end else if (cmd.pack_step) begin
            lag_vld_ff <= pack_issue;
            if (pack_issue) iss_k_ff <= iss_k_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_cell_state     <= '0;
         rsp_packed_word    <= '0;
         rsp_palette_zigzag <= '0;
         rsp_index_ok       <= 1'b0;
         case (op_type'(op_ff))
            OP_READ_CELL:
               rsp_cell_state <= (cell_rd_ff == '0) ? 32'd0 : pal_rd_ff;
            OP_READ_WORD: begin
               rsp_packed_word <= acc_ff;
               rsp_index_ok    <= wok_ff;
            end
            OP_READ_PAL: begin
               rsp_index_ok <= pal_ok;
               if (pal_ok && item_ff != 12'd0)
                  rsp_palette_zigzag <= {pal_rd_ff[30:0], 1'b0} ^ {32{pal_rd_ff[31]}};
            end
            default: rsp_cell_state <= '0;
         endcase
         rsp_bits_per_cell <= bpc;
         rsp_header_byte   <= {2'b00, bpc, 1'b1};
         rsp_word_count    <= words;
         rsp_palette_count <= used_ff;
         rsp_store_empty   <= used_ff == CNT_W'(1);
         rsp_palette_full  <= full_ff;
      end
   end

   always_comb begin
      status.clr_done  = clr_cnt_ff[CELL_AW-1:0] == CELL_AW'(CELL_COUNT - 1);
      status.srch_done = srch_done_ff;
      status.pack_done = !pack_issue && !lag_vld_ff;
      status.out_busy  = rsp_valid && !rsp_tready;
   end

endmodule
`default_nettype wire

/* sv/palette_block_store_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// palette block store packer: a 16x16x16 cube of cells, each holding an index
// into a growing palette of 32-bit states.
// input channel req_*: one transaction per command, req_tuser carries the op
// (write cell, read cell, read packed word, read palette entry).
// result channel rsp_*: exactly one result transaction per command.
// after reset the cell store is swept to zero, one cell per cycle, and
// req_tready stays low until the sweep is done.
// from accept to rsp_tvalid: a write scans the palette one entry per
// cycle through its read port, then commits; read cell reads the cell, then
// its palette entry; read palette entry reads the entry; read packed word
// walks the cell store one cell per cycle.
// one command is in work at a time; the result register lets the next
// command in while a result waits, and a stalled rsp_tready holds the
// result and blocks only the completion of the following command.
module palette_block_store_packer #(
   parameter int PALETTE_DEPTH = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // pos_x[3:0], pos_y[7:4], pos_z[11:8], new_state[43:12], item_index[55:44]
   input  wire logic [55:0] req_tdata,
   // op[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // cell_state, packed_word, palette_zigzag, bits_per_cell, header_byte,
   // word_count, palette_count, store_empty, palette_full, index_ok
   output logic [((124 + $clog2(PALETTE_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import pbsp_pkg::*;

   localparam int PA_W  = $clog2(PALETTE_DEPTH);
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam int RSP_W = ((124 + CNT_W + 7) / 8) * 8;

   cmd_type    cmd;
   status_type status;

   logic [31:0]      cell_state, packed_word, palette_zigzag;
   logic [4:0]       bits_per_cell;
   logic [7:0]       header_byte;
   logic [11:0]      word_count;
   logic [CNT_W-1:0] palette_count;
   logic             store_empty, palette_full, index_ok;

   pbsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pbsp_dpath #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .PA_W          (PA_W),
      .CNT_W         (CNT_W)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_tuser),
      .req_pos_x          (req_tdata[3:0]),
      .req_pos_y          (req_tdata[7:4]),
      .req_pos_z          (req_tdata[11:8]),
      .req_new_state      (req_tdata[43:12]),
      .req_item_index     (req_tdata[55:44]),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_cell_state     (cell_state),
      .rsp_packed_word    (packed_word),
      .rsp_palette_zigzag (palette_zigzag),
      .rsp_bits_per_cell  (bits_per_cell),
      .rsp_header_byte    (header_byte),
      .rsp_word_count     (word_count),
      .rsp_palette_count  (palette_count),
      .rsp_store_empty    (store_empty),
      .rsp_palette_full   (palette_full),
      .rsp_index_ok       (index_ok)
   );

   assign rsp_tdata = RSP_W'({index_ok, palette_full, store_empty, palette_count,
                              word_count, header_byte, bits_per_cell,
                              palette_zigzag, packed_word, cell_state});

endmodule
`default_nettype wire

/* sim/palette_block_store_packer_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module palette_block_store_packer_test;
   import pbsp_pkg::*;

   // default palette depth; enough new states to pass through every index width
   localparam int PAL_DEPTH = 4096;
   localparam int CNT_W     = $clog2(PAL_DEPTH + 1);
   localparam int RSP_W     = ((124 + CNT_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      op_type      op;
      logic [3:0]  x, y, z;
      logic [31:0] st;
      logic [11:0] idx;
   } item_type;

   typedef struct {
      logic [31:0]      cell_state, packed_word, zigzag;
      logic [4:0]       bpc;
      logic [7:0]       header;
      logic [11:0]      words;
      logic [CNT_W-1:0] count;
      logic             empty, full, ok;
   } expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   palette_block_store_packer #(.PALETTE_DEPTH(PAL_DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   item_type   pending_cmds[$];
   expect_type expected_status[$];
   item_type   cur_cmd;
   logic [31:0] palette_mirror[PAL_DEPTH];
   logic [11:0] cell_mirror[CELL_COUNT];
   int unsigned pal_used = 1;
   int errors = 0;
   int cycles = 0;

   function automatic logic [4:0] width_of(input int unsigned n);
      int unsigned b;
      b = 0;
      if (n < 2) n = 2;
      while (b < 31 && (1 << b) < n) b++;
      if (b > 8) b = 16;
      else if (b > 6) b = 8;
      return 5'(b);
   endfunction

   function automatic expect_type apply_cmd(input item_type c);
      expect_type r;
      int unsigned addr, i, per, wc, cel;
      r = '{default: '0};
      addr = {c.x, c.z, c.y};
      if (c.op == OP_WRITE_CELL) begin
         i = 0;
         while (i < pal_used && palette_mirror[i] != c.st) i++;
         if (i < pal_used) cell_mirror[addr] = 12'(i);
         else if (pal_used < PAL_DEPTH) begin
            palette_mirror[pal_used] = c.st;
            cell_mirror[addr] = 12'(pal_used);
            pal_used++;
         end else r.full = 1'b1;
      end else if (c.op == OP_READ_CELL) begin
         r.cell_state = palette_mirror[cell_mirror[addr]];
      end
      r.bpc = width_of(pal_used);
      per = 32 / r.bpc;
      wc = (CELL_COUNT + per - 1) / per;
      if (c.op == OP_READ_WORD && c.idx < wc) begin
         r.ok = 1'b1;
         for (int k = 0; k < per; k++) begin
            cel = c.idx * per + k;
            if (cel < CELL_COUNT)
               r.packed_word |= 32'(cell_mirror[cel]) << (k * r.bpc);
         end
      end else if (c.op == OP_READ_PAL && c.idx < pal_used) begin
         r.ok = 1'b1;
         r.zigzag = {palette_mirror[c.idx][30:0], 1'b0} ^ {32{palette_mirror[c.idx][31]}};
      end
      r.header = {2'b00, r.bpc, 1'b1};
      r.words = 12'(wc);
      r.count = CNT_W'(pal_used);
      r.empty = (pal_used == 1);
      return r;
   endfunction

   // sender: bursts and gaps
   int burst_left = 4, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_status = {expected_status, apply_cmd(cur_cmd)};
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               cur_cmd <= pending_cmds[0];
               req_tdata <= {pending_cmds[0].idx, pending_cmds[0].st, pending_cmds[0].z,
                             pending_cmds[0].y, pending_cmds[0].x};
               req_tuser <= pending_cmds[0].op;
               pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else burst_left <= burst_left - 1;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern with quiet stretches
   int stall_mode = 0;
   always @(posedge clock) begin
      expect_type e, a;
      cycles <= cycles + 1;
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      rsp_tready <= (stall_mode == 0) ? 1'b1 :
                    (stall_mode == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.cell_state  = rsp_tdata[31:0];
         a.packed_word = rsp_tdata[63:32];
         a.zigzag      = rsp_tdata[95:64];
         a.bpc         = rsp_tdata[100:96];
         a.header      = rsp_tdata[108:101];
         a.words       = rsp_tdata[120:109];
         a.count       = rsp_tdata[121 +: CNT_W];
         a.empty       = rsp_tdata[121 + CNT_W];
         a.full        = rsp_tdata[122 + CNT_W];
         a.ok          = rsp_tdata[123 + CNT_W];
         if (expected_status.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
         end else begin
            e = expected_status.pop_front();
            if (a.cell_state !== e.cell_state) begin
               $error("cell_state exp %h got %h", e.cell_state, a.cell_state); errors++;
            end
            if (a.packed_word !== e.packed_word) begin
               $error("packed_word exp %h got %h", e.packed_word, a.packed_word); errors++;
            end
            if (a.zigzag !== e.zigzag) begin
               $error("palette_zigzag exp %h got %h", e.zigzag, a.zigzag); errors++;
            end
            if (a.bpc !== e.bpc) begin
               $error("bits_per_cell exp %0d got %0d", e.bpc, a.bpc); errors++;
            end
            if (a.header !== e.header) begin
               $error("header_byte exp %h got %h", e.header, a.header); errors++;
            end
            if (a.words !== e.words) begin
               $error("word_count exp %0d got %0d", e.words, a.words); errors++;
            end
            if (a.count !== e.count) begin
               $error("palette_count exp %0d got %0d", e.count, a.count); errors++;
            end
            if (a.empty !== e.empty) begin
               $error("store_empty exp %b got %b", e.empty, a.empty); errors++;
            end
            if (a.full !== e.full) begin
               $error("palette_full exp %b got %b", e.full, a.full); errors++;
            end
            if (a.ok !== e.ok) begin
               $error("index_ok exp %b got %b", e.ok, a.ok); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic item_type make_cmd(input op_type op, input logic [3:0] x, y, z,
                                         input logic [31:0] st, input logic [11:0] idx);
      item_type c;
      c.op = op; c.x = x; c.y = y; c.z = z; c.st = st; c.idx = idx;
      return c;
   endfunction

   function automatic void enqueue_item(input item_type c);
      pending_cmds = {pending_cmds, c};
   endfunction

   logic [31:0] used_states[$];

   initial begin
      item_type c;
      int unsigned pick;
      for (int i = 0; i < PAL_DEPTH; i++) palette_mirror[i] = '0;
      for (int i = 0; i < CELL_COUNT; i++) cell_mirror[i] = '0;
      used_states = {used_states, 32'h0};
      // empty store first, then extremes of states and coordinates
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd0));
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd127));
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd128));
      enqueue_item(make_cmd(OP_READ_PAL, 0, 0, 0, 0, 12'd0));
      enqueue_item(make_cmd(OP_READ_PAL, 0, 0, 0, 0, 12'd4095));
      enqueue_item(make_cmd(OP_READ_CELL, 15, 15, 15, 0, 0));
      enqueue_item(make_cmd(OP_WRITE_CELL, 0, 0, 0, 32'h0, 0));
      enqueue_item(make_cmd(OP_WRITE_CELL, 15, 15, 15, 32'h8000_0000, 0));
      enqueue_item(make_cmd(OP_WRITE_CELL, 0, 0, 1, 32'h7FFF_FFFF, 0));
      enqueue_item(make_cmd(OP_WRITE_CELL, 15, 0, 0, 32'hFFFF_FFFF, 0));
      enqueue_item(make_cmd(OP_WRITE_CELL, 0, 15, 0, 32'h7FFF_FFFF, 0));
      enqueue_item(make_cmd(OP_READ_CELL, 15, 15, 15, 0, 0));
      enqueue_item(make_cmd(OP_READ_CELL, 0, 15, 0, 0, 0));
      for (int i = 0; i < 4; i++)
         enqueue_item(make_cmd(OP_READ_PAL, 0, 0, 0, 0, 12'(i)));
      enqueue_item(make_cmd(OP_READ_PAL, 0, 0, 0, 0, 12'd4));
      // last word and out-of-range indices at two bits per cell
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd0));
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd255));
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd256));
      enqueue_item(make_cmd(OP_READ_WORD, 0, 0, 0, 0, 12'd4095));
      used_states = {used_states, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};

      for (int n = 0; n < 1800; n++) begin
         c.x = 4'($urandom); c.y = 4'($urandom); c.z = 4'($urandom);
         c.st = 32'($urandom);
         c.idx = 12'($urandom);
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            c.op = OP_WRITE_CELL;
            if ($urandom_range(0, 1) == 0)
               c.st = used_states[$urandom_range(0, used_states.size() - 1)];
            else used_states = {used_states, c.st};
         end else if (pick < 6) c.op = OP_READ_CELL;
         else if (pick < 8) begin
            c.op = OP_READ_WORD;
            if ($urandom_range(0, 3) != 0) c.idx = 12'($urandom_range(0, 2100));
         end else begin
            c.op = OP_READ_PAL;
            if ($urandom_range(0, 3) != 0) c.idx = 12'($urandom_range(0, 420));
         end
         enqueue_item(c);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !req_tvalid && expected_status.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_status.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/pbsp_pkg.sv
sv/pbsp_ctrl.sv
sv/pbsp_dpath.sv
sv/palette_block_store_packer.sv
sim/palette_block_store_packer_test.sv
